// ===== rtl/core/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants for the partition fit allocator
// beat layouts, action and fit codes, scan record and cell control bundle
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int NUM_PARTITIONS = 16;
  localparam int SIZE_BITS      = 16;
  localparam int IDX_W          = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int COUNT_W        = 5;
  localparam int CMP_W          = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;
  localparam int CFG_W          = 5;
  localparam int CFG_IDX_W      = 1;
  localparam int REQNUM_W       = 8;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_ALLOC   = 2'd2
  } action_t;

  // fit rule codes, code three falls back to first fit
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 1'd1;

  localparam logic [COUNT_W-1:0] PART_COUNT_RESET = COUNT_W'(16);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    action_t      action;
    logic [3:0]   partition_index;
    logic [15:0]  size_kb;
  } req_t;

  typedef struct packed {
    logic         granted;
    logic [3:0]   chosen_partition;
    logic [15:0]  chosen_size_kb;
    logic [7:0]   request_number;
  } rsp_t;

  // record that walks down the row of cells during an allocate
  typedef struct packed {
    logic                 active;
    logic                 found;
    logic [IDX_W-1:0]     pick;
    logic [SIZE_BITS-1:0] pick_size;
    logic [15:0]          req_size;
    logic [1:0]           mode;
    logic [COUNT_W-1:0]   limit;
  } scan_t;

  // broadcast control from the top level to every cell
  typedef struct packed {
    logic                 load_en;
    logic [IDX_W-1:0]     load_idx;
    logic [SIZE_BITS-1:0] load_size;
    logic                 clear;
    logic                 mark_en;
    logic [IDX_W-1:0]     mark_idx;
  } cell_ctl_t;

endpackage

// ===== rtl/core/pfa_cell.sv =====
// ----------------------------------------------------------------------------
// pfa_cell: one partition slot of the allocator row
// holds one size and its in-use mark, refines the passing scan record
// ----------------------------------------------------------------------------
module pfa_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [pfa_pkg::IDX_W-1:0] idx,
  input  pfa_pkg::cell_ctl_t        ctl,
  input  pfa_pkg::scan_t            rec_in,
  output pfa_pkg::scan_t            rec_out
);

  logic [pfa_pkg::SIZE_BITS-1:0] size;
  logic                          used;
  logic                          in_range;
  logic                          big_enough;
  logic                          eligible;
  pfa_pkg::scan_t                rec_next;

  assign in_range   = pfa_pkg::CMP_W'(idx) < pfa_pkg::CMP_W'(rec_in.limit);
  assign big_enough = 32'(size) >= 32'(rec_in.req_size);
  assign eligible   = rec_in.active && !used && in_range && big_enough;

  always_comb begin
    rec_next = rec_in;
    if (eligible) begin
      if (!rec_in.found) begin
        rec_next.found     = 1'b1;
        rec_next.pick      = idx;
        rec_next.pick_size = size;
      end else if (rec_in.mode == pfa_pkg::FIT_BEST && size < rec_in.pick_size) begin
        rec_next.pick      = idx;
        rec_next.pick_size = size;
      end else if (rec_in.mode == pfa_pkg::FIT_WORST && size > rec_in.pick_size) begin
        rec_next.pick      = idx;
        rec_next.pick_size = size;
      end
    end
  end

  // size table entry, undefined until loaded
  always_ff @(posedge clk) begin
    if (ctl.load_en && ctl.load_idx == idx) begin
      size <= ctl.load_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= 1'b0;
      rec_out <= '0;
    end else begin
      rec_out <= rec_next;
      if (ctl.clear) begin
        used <= 1'b0;
      end else if (ctl.mark_en && ctl.mark_idx == idx) begin
        used <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/partition_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// partition_fit_allocator: fixed-partition allocator, first/best/worst fit
// row of partition cells scanned by a travelling search record
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid/req_stall/req) carries load, restart and allocate
//   beats. a load writes one partition size, a restart frees every partition
//   and zeroes the request counter; neither gives a result beat.
//   an allocate beat gives exactly one rsp beat (rsp_valid/rsp_stall/rsp).
//   cfg_we/cfg_index/cfg_data write fit_mode and partition_count; the user
//   must write them only while the block is idle, the block does not enforce it.
// sequencing
//   load and restart beats can be taken back to back while no result is held off.
//   an allocate walks a search record through the sixteen cells, one cell
//   per cycle, and its result is registered as the record leaves the row;
//   one allocate is in flight at a time and the next beat can be taken in
//   the same cycle as the result shows, unless the receiver holds it off.
// reset
//   rst is synchronous: all partitions free, counter zero, fit_mode first
//   fit, partition_count 16. sizes are not cleared and are undefined until
//   loaded.
// stalls
//   the result sits in an output register; while the receiver holds it off,
//   and while a scan runs, every request beat is held off.
// ----------------------------------------------------------------------------
module partition_fit_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  pfa_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output pfa_pkg::rsp_t                 rsp,
  input  logic                          cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0]     cfg_data
);

  localparam int N = pfa_pkg::NUM_PARTITIONS;

  pfa_pkg::state_t                  state;
  pfa_pkg::state_t                  state_next;
  logic [1:0]                       fit_mode;
  logic [pfa_pkg::COUNT_W-1:0]      partition_count;
  logic [pfa_pkg::REQNUM_W-1:0]     request_counter;

  pfa_pkg::scan_t                   chain [N+1];
  pfa_pkg::cell_ctl_t               ctl;
  logic [N-1:0]                     chain_active;

  logic                             req_fire;
  logic                             rsp_fire;
  logic                             done;
  logic                             inject;
  logic                             out_blocked;

  assign req_fire    = req_valid && !req_stall;
  assign rsp_fire    = rsp_valid && !rsp_stall;
  assign out_blocked = rsp_valid && rsp_stall;
  assign done        = chain[N].active;

  // ---- sequencer: next state ----
  always_comb begin
    state_next = state;
    case (state)
      pfa_pkg::ST_IDLE: begin
        if (req_fire && req.action == pfa_pkg::ACT_ALLOC) begin
          state_next = pfa_pkg::ST_SCAN;
        end
      end
      pfa_pkg::ST_SCAN: begin
        if (done) begin
          state_next = pfa_pkg::ST_IDLE;
        end
      end
      default: state_next = pfa_pkg::ST_IDLE;
    endcase
  end

  // ---- sequencer: outputs ----
  always_comb begin
    req_stall = 1'b1;
    inject    = 1'b0;
    case (state)
      pfa_pkg::ST_IDLE: begin
        // a waiting result only blocks while the receiver holds it off
        req_stall = out_blocked;
        inject    = req_fire && req.action == pfa_pkg::ACT_ALLOC;
      end
      pfa_pkg::ST_SCAN: begin
        req_stall = 1'b1;
      end
      default: req_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode        <= pfa_pkg::FIT_FIRST;
      partition_count <= pfa_pkg::PART_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pfa_pkg::CFG_FIT_MODE:   fit_mode        <= cfg_data[1:0];
        pfa_pkg::CFG_PART_COUNT: partition_count <= cfg_data[pfa_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- search record entering the row ----
  always_comb begin
    chain[0]           = '0;
    chain[0].active    = inject;
    chain[0].req_size  = req.size_kb;
    chain[0].mode      = fit_mode;
    chain[0].limit     = partition_count;
  end

  // ---- broadcast control to the cells ----
  always_comb begin
    ctl           = '0;
    ctl.load_en   = req_fire && req.action == pfa_pkg::ACT_LOAD &&
                    32'(req.partition_index) < 32'(N);
    ctl.load_idx  = pfa_pkg::IDX_W'(req.partition_index);
    ctl.load_size = pfa_pkg::SIZE_BITS'(req.size_kb);
    ctl.clear     = req_fire && req.action == pfa_pkg::ACT_RESTART;
    // the winner is marked as the record leaves the end of the row
    ctl.mark_en   = done && chain[N].found;
    ctl.mark_idx  = chain[N].pick;
  end

  // ---- the row of cells ----
  for (genvar g = 0; g < N; g++) begin : g_cell
    pfa_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (pfa_pkg::IDX_W'(g)),
      .ctl     (ctl),
      .rec_in  (chain[g]),
      .rec_out (chain[g+1])
    );
    assign chain_active[g] = chain[g+1].active;
  end

  // ---- request counter, saturating ----
  always_ff @(posedge clk) begin
    if (rst) begin
      request_counter <= '0;
    end else if (ctl.clear) begin
      request_counter <= '0;
    end else if (done && request_counter != '1) begin
      request_counter <= request_counter + 1'b1;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (rsp_fire) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp.granted          <= chain[N].found;
      rsp.chosen_partition <= chain[N].found ? 4'(chain[N].pick) : 4'd0;
      rsp.chosen_size_kb   <= chain[N].found ? 16'(chain[N].pick_size) : 16'd0;
      rsp.request_number   <= request_counter;
    end
  end

  // ---- assertions ----
  a_one_record: assert property (@(posedge clk) disable iff (rst)
    $countones(chain_active) <= 1)
    else $error("more than one search record in the row");

  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> state == pfa_pkg::ST_SCAN)
    else $error("scan finished outside a scan");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.granted |-> rsp.chosen_partition == 4'd0 && rsp.chosen_size_kb == 16'd0)
    else $error("refused result carries a partition");

  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    done |=> request_counter != $past(request_counter) || $past(request_counter) == '1)
    else $error("request counter did not advance");

endmodule
